// ===== design/stse_pkg.sv =====
// Package for the sorted table search engine.
// Field widths, codes, controller states and the control/status structs.
// No dependencies.
package stse_pkg;

  localparam int STSE_TABLE_DEPTH = 16;
  localparam int STSE_VALUE_WIDTH = 32;

  localparam int OPCODE_W  = 2;
  localparam int INDEX_W   = 4;
  localparam int OPERAND_W = 32;
  localparam int POS_W     = 4;
  localparam int COUNT_W   = 5;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_SORT   = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  localparam logic RK_SORT   = 1'b0;
  localparam logic RK_SEARCH = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_S_GAP,
    ST_S_CHECK,
    ST_S_CMP,
    ST_S_SWAP,
    ST_S_DONE,
    ST_Q_ISSUE,
    ST_Q_EVAL,
    ST_Q_DONE
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic wr_entry;
    logic sort_init;
    logic pass_init;
    logic pair_read;
    logic pair_wr_lo;
    logic pair_wr_hi;
    logic pair_next;
    logic gap_halve;
    logic srch_init;
    logic srch_issue;
    logic srch_eval;
    logic out_sort;
    logic out_search;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic gap_zero;
    logic pair_ok;
    logic changed;
    logic swap_need;
    logic stop;
    logic out_free;
  } status_t;

endpackage

// ===== design/stse_ifs.sv =====
// Channel interfaces of the sorted table search engine: request, response, config.
// Depends on stse_pkg.
interface stse_req_if;
  import stse_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [INDEX_W-1:0]   entry_index;
  logic [OPERAND_W-1:0] operand_value;
  modport source (output valid, opcode, entry_index, operand_value, input ready);
  modport sink   (input valid, opcode, entry_index, operand_value, output ready);
endinterface

interface stse_rsp_if;
  import stse_pkg::*;
  logic             valid;
  logic             ready;
  logic             result_kind;
  logic             key_found;
  logic [POS_W-1:0] found_position;
  modport source (output valid, result_kind, key_found, found_position, input ready);
  modport sink   (input valid, result_kind, key_found, found_position, output ready);
endinterface

interface stse_cfg_if;
  import stse_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] entries_in_use;
  modport source (output valid, entries_in_use, input ready);
  modport sink   (input valid, entries_in_use, output ready);
endinterface

// ===== design/stse_ctrl.sv =====
// Controller FSM: sequences clearing, writes, shell sort passes and probes.
// Depends on stse_pkg; drives stse_datapath through cmd_t, reads status_t.
module stse_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  logic [stse_pkg::OPCODE_W-1:0] req_opcode,
  output logic                      req_ready,
  input  stse_pkg::status_t         status,
  output stse_pkg::cmd_t            cmd
);
  import stse_pkg::*;

  state_t state, state_next;
  logic   req_fire;

  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (status.clr_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (req_fire) begin
          unique case (opcode_t'(req_opcode))
            OP_SORT:   state_next = ST_S_GAP;
            OP_SEARCH: state_next = ST_Q_ISSUE;
            OP_WRITE,
            OP_NONE:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_S_GAP:   state_next = status.gap_zero ? ST_S_DONE : ST_S_CHECK;
      ST_S_CHECK: begin
        priority if (status.pair_ok) state_next = ST_S_CMP;
        else if (status.changed)     state_next = ST_S_CHECK;
        else                         state_next = ST_S_GAP;
      end
      ST_S_CMP:   state_next = status.swap_need ? ST_S_SWAP : ST_S_CHECK;
      ST_S_SWAP:  state_next = ST_S_CHECK;
      ST_S_DONE:  if (status.out_free) state_next = ST_IDLE;
      ST_Q_ISSUE: state_next = ST_Q_EVAL;
      ST_Q_EVAL:  state_next = status.stop ? ST_Q_DONE : ST_Q_ISSUE;
      ST_Q_DONE:  if (status.out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_CLEAR:   cmd.clr_step = 1'b1;
      ST_IDLE: begin
        if (req_fire) begin
          unique case (opcode_t'(req_opcode))
            OP_WRITE:  cmd.wr_entry  = 1'b1;
            OP_SORT:   cmd.sort_init = 1'b1;
            OP_SEARCH: cmd.srch_init = 1'b1;
            OP_NONE:   ;
          endcase
        end
      end
      ST_S_GAP:   if (!status.gap_zero) cmd.pass_init = 1'b1;
      ST_S_CHECK: begin
        priority if (status.pair_ok) cmd.pair_read = 1'b1;
        else if (status.changed)     cmd.pass_init = 1'b1;
        else                         cmd.gap_halve = 1'b1;
      end
      ST_S_CMP: begin
        if (status.swap_need) cmd.pair_wr_lo = 1'b1;
        else                  cmd.pair_next  = 1'b1;
      end
      ST_S_SWAP: begin
        cmd.pair_wr_hi = 1'b1;
        cmd.pair_next  = 1'b1;
      end
      ST_S_DONE:  cmd.out_sort   = status.out_free;
      ST_Q_ISSUE: cmd.srch_issue = 1'b1;
      ST_Q_EVAL:  cmd.srch_eval  = 1'b1;
      ST_Q_DONE:  cmd.out_search = status.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

// ===== design/stse_datapath.sv =====
// Datapath: table memory, count register, sort and search registers, response register.
// Depends on stse_pkg; commanded by stse_ctrl.
module stse_datapath #(
  parameter int TABLE_DEPTH = stse_pkg::STSE_TABLE_DEPTH,
  parameter int VALUE_WIDTH = stse_pkg::STSE_VALUE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  stse_pkg::cmd_t                 cmd,
  output stse_pkg::status_t              status,
  input  logic [stse_pkg::INDEX_W-1:0]   entry_index,
  input  logic [stse_pkg::OPERAND_W-1:0] operand_value,
  input  logic                           cfg_we,
  input  logic [stse_pkg::COUNT_W-1:0]   cfg_count,
  input  logic                           rsp_ready,
  output logic                           rsp_valid,
  output logic                           rsp_kind,
  output logic                           rsp_found,
  output logic [stse_pkg::POS_W-1:0]     rsp_position
);
  import stse_pkg::*;

  localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_MAX = (TABLE_DEPTH < 31) ? TABLE_DEPTH : 31;
  localparam int CW      = $clog2(CNT_MAX + 1);

  logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_a, rd_b;

  logic [COUNT_W-1:0]     entries_in_use;
  logic [AW-1:0]          clr_addr;

  logic [CW-1:0]          count, gap, p, low, high, mid, prev;
  logic                   changed, have_prev, hit;
  logic [VALUE_WIDTH-1:0] key;

  logic [CW-1:0]          count_eff, mid_calc;
  logic [CW:0]            p_hi_sum, mid_sum;
  logic [CW-1:0]          p_hi;
  logic [63:0]            operand_ext;
  logic [VALUE_WIDTH-1:0] operand_v;
  logic                   match, less;
  logic [31:0]            mid32;

  logic                   we;
  logic [AW-1:0]          waddr, raddr_a, raddr_b;
  logic [VALUE_WIDTH-1:0] wdata;
  logic                   re;

  assign operand_ext = {32'b0, operand_value};
  assign operand_v   = operand_ext[VALUE_WIDTH-1:0];

  always_comb begin
    if (entries_in_use == '0)                 count_eff = CW'(1);
    else if (int'(entries_in_use) > TABLE_DEPTH) count_eff = CW'(TABLE_DEPTH);
    else                                       count_eff = CW'(entries_in_use);
  end

  assign p_hi_sum = {1'b0, p} + {1'b0, gap};
  assign p_hi     = p_hi_sum[CW-1:0];
  assign mid_sum  = {1'b0, low} + {1'b0, high};
  assign mid_calc = mid_sum[CW:1];
  assign match    = (rd_a == key);
  assign less     = ($signed(rd_a) < $signed(key));
  assign mid32    = 32'(mid);

  assign status.clr_last  = (clr_addr == AW'(TABLE_DEPTH - 1));
  assign status.gap_zero  = (gap == '0);
  assign status.pair_ok   = (p_hi_sum < {1'b0, count});
  assign status.changed   = changed;
  assign status.swap_need = ($signed(rd_a) > $signed(rd_b));
  assign status.stop      = match || (have_prev && (mid == prev));
  assign status.out_free  = !rsp_valid || rsp_ready;

  // single write port shared by clear, entry write and swap halves
  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = '0;
    priority if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.wr_entry) begin
      we    = (int'(entry_index) < TABLE_DEPTH);
      waddr = AW'(entry_index);
      wdata = operand_v;
    end else if (cmd.pair_wr_lo) begin
      we    = 1'b1;
      waddr = AW'(p);
      wdata = rd_b;
    end else if (cmd.pair_wr_hi) begin
      we    = 1'b1;
      waddr = AW'(p_hi);
      wdata = rd_a;
    end
  end

  assign re      = cmd.pair_read || cmd.srch_issue;
  assign raddr_a = cmd.srch_issue ? AW'(mid_calc) : AW'(p);
  assign raddr_b = AW'(p_hi);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) begin
      rd_a <= mem[raddr_a];
      rd_b <= mem[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr       <= '0;
      entries_in_use <= COUNT_RESET;
    end else begin
      if (cmd.clr_step && !status.clr_last) clr_addr <= clr_addr + AW'(1);
      if (cfg_we) entries_in_use <= cfg_count;
    end
  end

  // sort and search registers
  always_ff @(posedge clk) begin
    if (cmd.sort_init) begin
      count <= count_eff;
      gap   <= count_eff >> 1;
    end
    if (cmd.gap_halve) gap <= gap >> 1;
    if (cmd.pass_init) begin
      p       <= '0;
      changed <= 1'b0;
    end
    if (cmd.pair_wr_lo) changed <= 1'b1;
    if (cmd.pair_next)  p <= p + CW'(1);
    if (cmd.srch_init) begin
      count     <= count_eff;
      low       <= '0;
      high      <= count_eff;
      have_prev <= 1'b0;
      key       <= operand_v;
    end
    if (cmd.srch_issue) mid <= mid_calc;
    if (cmd.srch_eval) begin
      hit <= match;
      if (!match) begin
        if (less) low  <= mid;
        else      high <= mid;
      end
      prev      <= mid;
      have_prev <= 1'b1;
    end
  end

  // response word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_sort || cmd.out_search) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_sort) begin
      rsp_kind     <= RK_SORT;
      rsp_found    <= 1'b0;
      rsp_position <= '0;
    end else if (cmd.out_search) begin
      rsp_kind     <= RK_SEARCH;
      rsp_found    <= hit;
      rsp_position <= hit ? mid32[POS_W-1:0] : '0;
    end
  end

endmodule

// ===== design/sorted_table_search_engine.sv =====
// Top level of the sorted table search engine: controller plus datapath.
// Depends on stse_pkg, stse_ifs, stse_ctrl, stse_datapath.
//
//  channel | dir | word
//  req     | in  | opcode, entry_index, operand_value
//  rsp     | out | result_kind, key_found, found_position
//  cfg     | in  | entries_in_use (always ready)
//
// After reset the table is zeroed one entry a cycle, with req.ready low until it is cleared.
// A write completes in the idle state. Search: each probe is a memory read, then a compare.
// Sort: each pair is read, then compared, and a swap then writes its two halves in turn; passes
// run over every gap, and the single memory write port sets the swap cost.
// A finished word waits in the response register; a new request is taken meanwhile.
module sorted_table_search_engine #(
  parameter int TABLE_DEPTH = stse_pkg::STSE_TABLE_DEPTH,
  parameter int VALUE_WIDTH = stse_pkg::STSE_VALUE_WIDTH
) (
  input logic        clk,
  input logic        rst,
  stse_req_if.sink   req,
  stse_rsp_if.source rsp,
  stse_cfg_if.sink   cfg
);
  import stse_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg.ready = 1'b1;

  stse_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .req_ready  (req.ready),
    .status     (status),
    .cmd        (cmd)
  );

  stse_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .entry_index   (req.entry_index),
    .operand_value (req.operand_value),
    .cfg_we        (cfg.valid),
    .cfg_count     (cfg.entries_in_use),
    .rsp_ready     (rsp.ready),
    .rsp_valid     (rsp.valid),
    .rsp_kind      (rsp.result_kind),
    .rsp_found     (rsp.key_found),
    .rsp_position  (rsp.found_position)
  );

endmodule

// ===== verif/stse_checker.sv =====
// Checker for the sorted table search engine: keeps its own copy of the table and count,
// predicts each answer word from the request words and compares the response words.
// Depends on stse_pkg and stse_ifs.
module stse_checker (
  input  logic        clk,
  input  logic        rst,
  stse_req_if         req,
  stse_rsp_if         rsp,
  stse_cfg_if         cfg,
  output int unsigned mismatches,
  output int unsigned outstanding
);
  import stse_pkg::*;

  typedef struct packed {
    logic             kind;
    logic             found;
    logic [POS_W-1:0] pos;
  } answer_t;

  logic signed [STSE_VALUE_WIDTH-1:0] entry_vals [STSE_TABLE_DEPTH];
  logic [COUNT_W-1:0] count_reg;
  answer_t            expected_answers [$];
  answer_t            got_ans;
  answer_t            want_ans;
  int unsigned        fails = 0;

  function automatic int unsigned span();
    int unsigned n;
    n = count_reg;
    if (n == 0) n = 1;
    if (n > STSE_TABLE_DEPTH) n = STSE_TABLE_DEPTH;
    return n;
  endfunction

  function automatic void shell_order();
    int unsigned n, gap;
    bit swapped;
    logic signed [STSE_VALUE_WIDTH-1:0] t;
    n = span();
    gap = n / 2;
    while (gap > 0) begin
      do begin
        swapped = 1'b0;
        for (int unsigned p = 0; p + gap < n; p++) begin
          if (entry_vals[p] > entry_vals[p + gap]) begin
            t = entry_vals[p];
            entry_vals[p] = entry_vals[p + gap];
            entry_vals[p + gap] = t;
            swapped = 1'b1;
          end
        end
      end while (swapped);
      gap = gap / 2;
    end
  endfunction

  function automatic answer_t probe_answer(logic signed [STSE_VALUE_WIDTH-1:0] key);
    int unsigned low, high, mid, prev;
    bit have_prev;
    answer_t a;
    low = 0;
    high = span();
    prev = 0;
    have_prev = 1'b0;
    while (1) begin
      mid = (low + high) / 2;
      if (mid >= STSE_TABLE_DEPTH) mid = STSE_TABLE_DEPTH - 1;
      if (entry_vals[mid] == key) break;
      if (entry_vals[mid] < key) low = mid;
      else high = mid;
      if (have_prev && mid == prev) break;
      prev = mid;
      have_prev = 1'b1;
    end
    a.kind = RK_SEARCH;
    a.found = (entry_vals[mid] == key);
    a.pos = a.found ? mid[POS_W-1:0] : '0;
    return a;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (fails < 100) $display("mismatch in %s: got %0d, expected %0d", what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (entry_vals[i]) entry_vals[i] = '0;
      count_reg = COUNT_RESET;
      expected_answers.delete();
    end else begin
      if (cfg.valid && cfg.ready) count_reg = cfg.entries_in_use;
      if (rsp.valid && rsp.ready) begin
        got_ans = '{rsp.result_kind, rsp.key_found, rsp.found_position};
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected word, result_kind", got_ans.kind, 0);
        end else begin
          want_ans = expected_answers.pop_front();
          if (got_ans.kind !== want_ans.kind)
            report_mismatch("result_kind", got_ans.kind, want_ans.kind);
          if (got_ans.found !== want_ans.found)
            report_mismatch("key_found", got_ans.found, want_ans.found);
          if (got_ans.pos !== want_ans.pos)
            report_mismatch("found_position", got_ans.pos, want_ans.pos);
        end
      end
      if (req.valid && req.ready) begin
        case (opcode_t'(req.opcode))
          OP_WRITE: entry_vals[req.entry_index] = req.operand_value;
          OP_SORT: begin
            shell_order();
            expected_answers.push_back('{RK_SORT, 1'b0, '0});
          end
          OP_SEARCH: expected_answers.push_back(probe_answer(req.operand_value));
          default: ;
        endcase
      end
    end
    mismatches  <= fails;
    outstanding <= expected_answers.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the sorted table search engine testbench: clock, reset, stimulus and verdict.
// Depends on stse_pkg, stse_ifs, sorted_table_search_engine and stse_checker.
module testbench;
  import stse_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;

  logic        clk;
  logic        rst;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches;
  int unsigned outstanding;
  logic [OPERAND_W-1:0] shadow [STSE_TABLE_DEPTH];

  stse_req_if req ();
  stse_rsp_if rsp ();
  stse_cfg_if cfg ();

  sorted_table_search_engine u_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  stse_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .cfg        (cfg),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_word(opcode_t op, logic [INDEX_W-1:0] idx, logic [OPERAND_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid         <= 1'b1;
    req.opcode        <= op;
    req.entry_index   <= idx;
    req.operand_value <= val;
    do @(posedge clk); while (!req.ready);
    if (op == OP_WRITE) shadow[idx] = val;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_count(logic [COUNT_W-1:0] n);
    cfg.valid          <= 1'b1;
    cfg.entries_in_use <= n;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [OPERAND_W-1:0] pick_value();
    int v;
    v = int'($urandom_range(20)) - 10;
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return v;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_phase(int unsigned n_items);
    int unsigned sent;
    int unsigned r;
    int unsigned k;
    int unsigned w;
    logic [OPERAND_W-1:0] key;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 70) begin
        w = $urandom_range(1, STSE_TABLE_DEPTH);
        repeat (w) send_word(OP_WRITE, INDEX_W'($urandom_range(15)), pick_value());
        send_word(OP_SORT, INDEX_W'($urandom_range(15)), $urandom());
        k = $urandom_range(1, 6);
        sent += w + 1 + k;
        repeat (k) begin
          key = ($urandom_range(3) == 0) ? pick_value()
                                         : shadow[INDEX_W'($urandom_range(15))];
          send_word(OP_SEARCH, INDEX_W'($urandom_range(15)), key);
        end
      end else if (r < 85) begin
        key = $urandom_range(1) ? pick_value() : shadow[INDEX_W'($urandom_range(15))];
        send_word(OP_SEARCH, INDEX_W'($urandom_range(15)), key);
        sent++;
      end else if (r < 95) begin
        send_word(OP_SORT, INDEX_W'($urandom_range(15)), $urandom());
        sent++;
      end else begin
        send_word(OP_NONE, INDEX_W'($urandom_range(15)), $urandom());
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned count_plan [12];
    int unsigned idle_plan  [4];
    int unsigned stall_plan [4];
    count_plan = '{16, 1, 0, 31, 17, 2, 3, 8, 9, 15, 5, 16};
    idle_plan  = '{0, 76, 0, 34};
    stall_plan = '{0, 0, 76, 34};
    foreach (shadow[i]) shadow[i] = '0;
    rst                = 1'b1;
    req.valid          = 1'b0;
    req.opcode         = OP_NONE;
    req.entry_index    = '0;
    req.operand_value  = '0;
    cfg.valid          = 1'b0;
    cfg.entries_in_use = COUNT_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // cleared table, then extremes at both ends
    send_word(OP_SEARCH, 4'd0, 32'h0000_0000);
    send_word(OP_SEARCH, 4'd15, 32'h8000_0000);
    send_word(OP_SEARCH, 4'd0, 32'h7FFF_FFFF);
    send_word(OP_WRITE, 4'd0, 32'h7FFF_FFFF);
    send_word(OP_WRITE, 4'd15, 32'h8000_0000);
    send_word(OP_WRITE, 4'd7, 32'hFFFF_FFFF);
    send_word(OP_WRITE, 4'd3, 32'h0000_0001);
    send_word(OP_NONE, 4'd15, 32'hFFFF_FFFF);
    send_word(OP_SORT, 4'd0, 32'h0000_0000);
    send_word(OP_SEARCH, 4'd0, 32'h8000_0000);
    send_word(OP_SEARCH, 4'd0, 32'h7FFF_FFFF);
    send_word(OP_SEARCH, 4'd0, 32'hFFFF_FFFF);
    send_word(OP_SEARCH, 4'd0, 32'h0000_0001);
    send_word(OP_SEARCH, 4'd0, 32'h0000_0002);
    send_word(OP_SEARCH, 4'd0, 32'h0000_0000);
    send_word(OP_SORT, 4'd15, 32'hFFFF_FFFF);
    drain();

    for (int p = 0; p < 12; p++) begin
      set_count(COUNT_W'(count_plan[p]));
      idle_pct  = idle_plan[p % 4];
      stall_pct = stall_plan[p % 4];
      random_phase(52);
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/stse_pkg.sv
design/stse_ifs.sv
design/stse_ctrl.sv
design/stse_datapath.sv
design/sorted_table_search_engine.sv
verif/stse_checker.sv
verif/testbench.sv
